/* rtl/core/isru_pkg.sv */
// Shared types and constants of the inverse square root activation unit.
`default_nettype none

package isru_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W   = 32;
    localparam int WEIGHT_W   = 32;
    localparam int ALPHA_W    = 24;
    localparam int ALPHA_FRAC = 16;
    localparam int ISR_W      = 17;
    localparam int ISR_FRAC   = 16;
    localparam int ACT_W      = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd1;

    // Register reset values.
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 24'd65536;
    localparam logic               MODE_RESET  = 1'b1;

    // One sample split into sign and magnitude, with its weight.
    typedef struct packed {
        logic                neg;
        logic [SAMPLE_W-1:0] mag;
        logic [WEIGHT_W-1:0] weight;
    } t_elem;

endpackage

`default_nettype wire

/* rtl/core/isru_weighted_activation_core.sv */
// Top level of the weighted inverse square root activation unit.
`default_nettype none

// One item is taken at every clock edge at which i_start is high; o_busy stays
// low, so the unit runs at one item per cycle with no gaps. Each result is strobed
// by o_valid for one cycle, in the order the items came in. The depth is set by
// the row of FRAC_BITS + 25 cells that finds the reciprocal root of alpha one
// bit per cell; the 17-cell row for 1/sqrt(1 + alpha*x*x) runs beside it after
// four front stages, and four back stages form and weight the activation. The
// receiver cannot stall the unit. Registers are written through the plain write
// port and should change only while no item is in flight.
module isru_weighted_activation_core import isru_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_in,
    input  wire logic [WEIGHT_W-1:0]   i_weight_in,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_valid,
    output logic [ISR_W-1:0]           o_inv_sqrt_out,
    output logic [ACT_W-1:0]           o_activation_out,
    output logic                       o_saturated
);

    localparam int TEXP    = 2 * ISR_FRAC + ALPHA_FRAC + 2 * FRAC_BITS;
    localparam int NR      = FRAC_BITS + ISR_FRAC + ALPHA_FRAC / 2 + 1;
    localparam int RAW     = 2 * NR + ALPHA_W + 1;
    localparam int AX_W    = ALPHA_W + 2 * (SAMPLE_W - 1);
    localparam int DWI     = ((ALPHA_FRAC + 2 * FRAC_BITS > AX_W) ?
                              (ALPHA_FRAC + 2 * FRAC_BITS) : AX_W) + 1;
    localparam int NI      = ISR_W;
    localparam int IAW     = 2 * ISR_W + DWI + 1;
    localparam int DEN_LAT = 4;
    localparam int DLY     = NR - DEN_LAT - NI;
    localparam int ELEM_D  = NI + DLY;

    logic [ALPHA_W-1:0] r_alpha_scale;
    logic               r_weighted_mode;
    logic [ALPHA_W-1:0] c_alpha;
    logic               c_accept;

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_scale   <= ALPHA_RESET;
            r_weighted_mode <= MODE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALPHA: r_alpha_scale   <= i_cfg_data[ALPHA_W-1:0];
                CFG_MODE:  r_weighted_mode <= i_cfg_data[0];
                default:   ;
            endcase
        end
    end

    // A zero alpha acts as the smallest positive alpha.
    assign c_alpha  = (r_alpha_scale == '0) ? {{(ALPHA_W-1){1'b0}}, 1'b1} : r_alpha_scale;
    assign o_busy   = 1'b0;
    assign c_accept = i_start & ~o_busy;

    // Row for r = 2^(FRAC_BITS+24) / sqrt(alpha), starting at the item's own edge.
    logic             rv [0:NR];
    logic [NR-1:0]    rq [0:NR];
    logic [RAW-1:0]   rp [0:NR];
    logic [RAW-1:0]   ry [0:NR];
    logic [ALPHA_W-1:0] rd [0:NR];

    assign rv[0] = c_accept;
    assign rq[0] = '0;
    assign rp[0] = '0;
    assign ry[0] = '0;
    assign rd[0] = c_alpha;

    for (genvar k = 0; k < NR; k++) begin : g_rrow
        isru_root_cell #(
            .W    (RAW),
            .DW   (ALPHA_W),
            .QW   (NR),
            .BIT  (NR - 1 - k),
            .TEXP (TEXP)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (rv[k]),
            .i_q     (rq[k]),
            .i_p     (rp[k]),
            .i_y     (ry[k]),
            .i_d     (rd[k]),
            .o_valid (rv[k+1]),
            .o_q     (rq[k+1]),
            .o_p     (rp[k+1]),
            .o_y     (ry[k+1]),
            .o_d     (rd[k+1])
        );
    end

    // Front stages form the operand of the second root.
    logic           den_valid;
    t_elem          den_elem;
    logic [DWI-1:0] den_d;

    isru_den #(
        .FRAC_BITS (FRAC_BITS),
        .DW        (DWI)
    ) u_den (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_accept),
        .i_sample (i_sample_in),
        .i_weight (i_weight_in),
        .i_alpha  (c_alpha),
        .o_valid  (den_valid),
        .o_elem   (den_elem),
        .o_d      (den_d)
    );

    // Row for isr = 2^16 / sqrt(1 + alpha*x*x).
    logic             iv [0:NI];
    logic [ISR_W-1:0] iq [0:NI];
    logic [IAW-1:0]   ip [0:NI];
    logic [IAW-1:0]   iy [0:NI];
    logic [DWI-1:0]   id [0:NI];

    assign iv[0] = den_valid;
    assign iq[0] = '0;
    assign ip[0] = '0;
    assign iy[0] = '0;
    assign id[0] = den_d;

    for (genvar k = 0; k < NI; k++) begin : g_irow
        isru_root_cell #(
            .W    (IAW),
            .DW   (DWI),
            .QW   (ISR_W),
            .BIT  (NI - 1 - k),
            .TEXP (TEXP)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (iv[k]),
            .i_q     (iq[k]),
            .i_p     (ip[k]),
            .i_y     (iy[k]),
            .i_d     (id[k]),
            .o_valid (iv[k+1]),
            .o_q     (iq[k+1]),
            .o_p     (ip[k+1]),
            .o_y     (iy[k+1]),
            .o_d     (id[k+1])
        );
    end

    // Delay lines that line the shorter path up with the end of the alpha row.
    t_elem            r_elem_dly  [0:ELEM_D-1];
    logic [ISR_W-1:0] r_isr_dly   [0:DLY-1];
    logic             r_ivld_dly  [0:DLY-1];

    always_ff @(posedge i_clk) begin
        r_elem_dly[0] <= den_elem;
        for (int j = 1; j < ELEM_D; j++) begin
            r_elem_dly[j] <= r_elem_dly[j-1];
        end
        r_isr_dly[0] <= iq[NI];
        for (int j = 1; j < DLY; j++) begin
            r_isr_dly[j] <= r_isr_dly[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DLY; j++) begin
                r_ivld_dly[j] <= 1'b0;
            end
        end else begin
            r_ivld_dly[0] <= iv[NI];
            for (int j = 1; j < DLY; j++) begin
                r_ivld_dly[j] <= r_ivld_dly[j-1];
            end
        end
    end

    // Back stages build and weight the activation.
    isru_act #(
        .FRAC_BITS (FRAC_BITS)
    ) u_act (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_ivld_dly[DLY-1] & rv[NR]),
        .i_elem     (r_elem_dly[ELEM_D-1]),
        .i_isr      (r_isr_dly[DLY-1]),
        .i_r        (rq[NR]),
        .i_weighted (r_weighted_mode),
        .o_valid    (o_valid),
        .o_inv_sqrt (o_inv_sqrt_out),
        .o_act      (o_activation_out),
        .o_sat      (o_saturated)
    );

endmodule

`default_nettype wire

/* rtl/core/isru_root_cell.sv */
// One cell of a bit-serial root row: decides one result bit per clock.
`default_nettype none

module isru_root_cell import isru_pkg::*; #(
    parameter int W    = 107,
    parameter int DW   = 24,
    parameter int QW   = 41,
    parameter int BIT  = 0,
    parameter int TEXP = 80
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [QW-1:0] i_q,
    input  wire logic [W-1:0]  i_p,
    input  wire logic [W-1:0]  i_y,
    input  wire logic [DW-1:0] i_d,
    output logic               o_valid,
    output logic [QW-1:0]      o_q,
    output logic [W-1:0]       o_p,
    output logic [W-1:0]       o_y,
    output logic [DW-1:0]      o_d
);

    // The row keeps p = q*q*d and y = q*d, so trying q + 2^BIT needs only shifts
    // and adds: (q + 2^BIT)^2 * d = p + (y << BIT+1) + (d << 2*BIT).
    logic [W-1:0] c_target;
    logic [W-1:0] c_dext;
    logic [W-1:0] c_sum;
    logic         c_ok;

    logic          r_valid;
    logic [QW-1:0] r_q;
    logic [W-1:0]  r_p;
    logic [W-1:0]  r_y;
    logic [DW-1:0] r_d;
    logic [QW-1:0] n_q;
    logic [W-1:0]  n_p;
    logic [W-1:0]  n_y;

    assign c_target = {{(W-1){1'b0}}, 1'b1} << TEXP;
    assign c_dext   = {{(W-DW){1'b0}}, i_d};
    assign c_sum    = i_p + (i_y << (BIT + 1)) + (c_dext << (2 * BIT));
    assign c_ok     = (c_sum <= c_target);

    // Keep the bit when the squared candidate stays within the target.
    always_comb begin
        n_q = i_q;
        n_p = i_p;
        n_y = i_y;
        if (c_ok) begin
            n_q = i_q | ({{(QW-1){1'b0}}, 1'b1} << BIT);
            n_p = c_sum;
            n_y = i_y + (c_dext << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        r_p <= n_p;
        r_y <= n_y;
        r_d <= i_d;
    end

    assign o_valid = r_valid;
    assign o_q     = r_q;
    assign o_p     = r_p;
    assign o_y     = r_y;
    assign o_d     = r_d;

endmodule

`default_nettype wire

/* rtl/core/isru_den.sv */
// Front pipeline: splits the sample and forms the root operand 1 + alpha*x*x.
`default_nettype none

module isru_den import isru_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int DW        = 87
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic [WEIGHT_W-1:0] i_weight,
    input  wire logic [ALPHA_W-1:0]  i_alpha,
    output logic                     o_valid,
    output t_elem                    o_elem,
    output logic [DW-1:0]            o_d
);

    localparam int SQ_W = 2 * SAMPLE_W - 1;
    localparam int PL_W = ALPHA_W + 32;
    localparam int PH_W = ALPHA_W + SQ_W - 32;

    logic [3:0]           r_valid;
    t_elem                r_e1;
    t_elem                r_e2;
    t_elem                r_e3;
    t_elem                r_e4;
    logic [SQ_W-1:0]      r_m2;
    logic [PL_W-1:0]      r_pl;
    logic [PH_W-1:0]      r_ph;
    logic [DW-1:0]        r_d;
    t_elem                n_e1;
    logic [2*SAMPLE_W-1:0] c_sq;
    logic [DW-1:0]        c_base;

    // Sign and magnitude; the most negative sample gives magnitude 2^31.
    always_comb begin
        n_e1.neg    = i_sample[SAMPLE_W-1];
        n_e1.mag    = n_e1.neg ? (~i_sample + 32'd1) : i_sample;
        n_e1.weight = i_weight;
    end

    assign c_sq   = r_e1.mag * r_e1.mag;
    assign c_base = {{(DW-1){1'b0}}, 1'b1} << (ALPHA_FRAC + 2 * FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    // Square, split product by alpha, then the final sum with the one term.
    always_ff @(posedge i_clk) begin
        r_e1 <= n_e1;
        r_e2 <= r_e1;
        r_m2 <= c_sq[SQ_W-1:0];
        r_e3 <= r_e2;
        r_pl <= PL_W'(i_alpha) * PL_W'(r_m2[31:0]);
        r_ph <= PH_W'(i_alpha) * PH_W'(r_m2[SQ_W-1:32]);
        r_e4 <= r_e3;
        r_d  <= c_base + DW'(r_pl) + (DW'(r_ph) << 32);
    end

    assign o_valid = r_valid[3];
    assign o_elem  = r_e4;
    assign o_d     = r_d;

endmodule

`default_nettype wire

/* rtl/core/isru_act.sv */
// Back pipeline: forms x*isr + r, weights it in weighted mode, saturates.
`default_nettype none

module isru_act import isru_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire t_elem                     i_elem,
    input  wire logic [ISR_W-1:0]          i_isr,
    input  wire logic [FRAC_BITS+24:0]     i_r,
    input  wire logic                      i_weighted,
    output logic                           o_valid,
    output logic [ISR_W-1:0]               o_inv_sqrt,
    output logic [ACT_W-1:0]               o_act,
    output logic                           o_sat
);

    localparam int RW  = FRAC_BITS + 25;
    localparam int PMW = SAMPLE_W + ISR_W - 1;
    localparam int UW  = ((RW > PMW) ? RW : PMW) + 1;
    localparam int PW  = UW + WEIGHT_W;
    localparam int SH  = ISR_FRAC + FRAC_BITS;

    logic [3:0]          r_valid;
    logic [PMW-1:0]      r_pm;
    logic [RW-1:0]       r_ra;
    logic                r_nega;
    logic [WEIGHT_W-1:0] r_wa;
    logic [WEIGHT_W-1:0] r_wb;
    logic [ISR_W-1:0]    r_isra;
    logic [ISR_W-1:0]    r_isrb;
    logic [ISR_W-1:0]    r_isrc;
    logic [ISR_W-1:0]    r_isr;
    logic [UW-1:0]       r_u;
    logic [UW-1:0]       r_uc;
    logic [63:0]         r_pl;
    logic [UW-1:0]       r_ph;
    logic [ACT_W-1:0]    r_act;
    logic                r_sat;
    logic [2*SAMPLE_W-1:0] c_pm;
    logic [UW-1:0]       c_rext;
    logic [UW-1:0]       c_pmext;
    logic [UW-1:0]       n_u;
    logic [PW-1:0]       c_p;
    logic [ACT_W-1:0]    n_act;
    logic                n_sat;

    assign c_pm    = 64'(i_elem.mag) * 64'(i_isr);
    assign c_rext  = UW'(r_ra);
    assign c_pmext = UW'(r_pm);

    // Signed sum in sign and magnitude form, clamped at zero.
    always_comb begin
        if (r_nega) begin
            n_u = (c_pmext > c_rext) ? '0 : (c_rext - c_pmext);
        end else begin
            n_u = c_rext + c_pmext;
        end
    end

    // Recombine the split weight product and drop the fraction bits.
    assign c_p = PW'(r_pl) + (PW'(r_ph) << 32);

    always_comb begin
        if (i_weighted) begin
            n_act = c_p[SH+ACT_W-1:SH];
            n_sat = |c_p[PW-1:SH+ACT_W];
        end else begin
            n_act = r_uc[ISR_FRAC+ACT_W-1:ISR_FRAC];
            n_sat = |r_uc[UW-1:ISR_FRAC+ACT_W];
        end
        if (n_sat) begin
            n_act = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_pm   <= c_pm[PMW-1:0];
        r_ra   <= i_r;
        r_nega <= i_elem.neg;
        r_wa   <= i_elem.weight;
        r_isra <= i_isr;
        r_u    <= n_u;
        r_wb   <= r_wa;
        r_isrb <= r_isra;
        r_pl   <= 64'(r_u[31:0]) * 64'(r_wb);
        r_ph   <= UW'(r_u[UW-1:32]) * UW'(r_wb);
        r_uc   <= r_u;
        r_isrc <= r_isrb;
        r_act  <= n_act;
        r_sat  <= n_sat;
        r_isr  <= r_isrc;
    end

    assign o_valid    = r_valid[3];
    assign o_inv_sqrt = r_isr;
    assign o_act      = r_act;
    assign o_sat      = r_sat;

endmodule

`default_nettype wire
